[sv/ute_pkg.sv]
// Shared types and constants for the UTF-8 terminal output encoder.
package ute_pkg;

    // Field widths
    localparam int OP_W        = 2;
    localparam int CP_W        = 21;
    localparam int CW_W        = 8;
    localparam int BYTE_W      = 8;
    localparam int COLUMN_W    = 16;
    localparam int MAX_BYTES   = 4;
    localparam int IDX_W       = 2;

    // Stream payload widths
    localparam int S_TDATA_W   = 32;
    localparam int S_TUSER_W   = OP_W;
    localparam int M_TDATA_W   = 24;
    localparam int M_TUSER_W   = 2;

    // Defaults for top-level parameters
    localparam int COLUMN_BITS_DEF = 16;
    localparam int QUEUE_DEPTH     = 2;

    // Code point ranges
    localparam logic [CP_W-1:0] CP_2BYTE_MIN = 21'h00_0080;
    localparam logic [CP_W-1:0] CP_3BYTE_MIN = 21'h00_0800;
    localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h00_D800;
    localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h00_E000;
    localparam logic [CP_W-1:0] CP_4BYTE_MIN = 21'h01_0000;
    localparam logic [CP_W-1:0] CP_LIMIT     = 21'h11_0000;
    localparam logic [CP_W-1:0] CP_CR        = 21'h00_000D;

    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_CHAR    = 2'd0,
        OP_RAW     = 2'd1,
        OP_NEWLINE = 2'd2,
        OP_FRESH   = 2'd3
    } op_t;

    // One classified item, handed from front to back
    typedef struct packed {
        logic                                byte_valid;
        logic                                encode_error;
        logic [IDX_W-1:0]                    last_idx;
        logic [MAX_BYTES-1:0][BYTE_W-1:0]    bytes;
        logic [COLUMN_W-1:0]                 column;
    } job_t;

    // Queue status seen by the front
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

[sv/ute_front.sv]
// Front end: accepts items, encodes UTF-8 and tracks the output column.
module ute_front #(
    parameter int COLUMN_BITS = ute_pkg::COLUMN_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [20:0] code_point, [28:21] char_width, [31:29] zero
    input  logic [ute_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] op
    input  logic [ute_pkg::S_TUSER_W-1:0] s_axis_tuser,
    input  ute_pkg::q_stat_t              q_stat,
    output logic                          push,
    output ute_pkg::job_t                 push_job
);
    import ute_pkg::*;

    logic [COLUMN_BITS-1:0] col_reg;
    logic [COLUMN_BITS-1:0] col_next;
    logic [COLUMN_BITS:0]   col_sum;
    logic [CP_W-1:0]        cp;
    logic [CW_W-1:0]        cw;
    logic                   cp_bad;
    logic                   accept;
    logic [MAX_BYTES-1:0][BYTE_W-1:0] utf_bytes;
    logic [IDX_W-1:0]       utf_last;

    assign cp            = s_axis_tdata[CP_W-1:0];
    assign cw            = s_axis_tdata[CP_W+CW_W-1:CP_W];
    assign s_axis_tready = !q_stat.full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push          = accept;

    // Surrogates and values past the Unicode range
    assign cp_bad = (cp >= CP_SURR_LO && cp < CP_SURR_HI) || (cp >= CP_LIMIT);

    // UTF-8 byte sequence, first byte in slot 0
    always_comb
    begin
        utf_bytes = '0;
        utf_last  = '0;
        if (cp < CP_2BYTE_MIN)
        begin
            utf_bytes[0] = cp[7:0];
        end
        else if (cp < CP_3BYTE_MIN)
        begin
            utf_bytes[0] = {3'b110, cp[10:6]};
            utf_bytes[1] = {2'b10, cp[5:0]};
            utf_last     = 2'd1;
        end
        else if (cp < CP_4BYTE_MIN)
        begin
            utf_bytes[0] = {4'b1110, cp[15:12]};
            utf_bytes[1] = {2'b10, cp[11:6]};
            utf_bytes[2] = {2'b10, cp[5:0]};
            utf_last     = 2'd2;
        end
        else
        begin
            utf_bytes[0] = {5'b11110, cp[20:18]};
            utf_bytes[1] = {2'b10, cp[17:12]};
            utf_bytes[2] = {2'b10, cp[11:6]};
            utf_bytes[3] = {2'b10, cp[5:0]};
            utf_last     = 2'd3;
        end
    end

    // Saturating column advance
    assign col_sum = {1'b0, col_reg} + (COLUMN_BITS+1)'(cw);

    // Classify the item and work out the next column
    always_comb
    begin
        col_next              = col_reg;
        push_job.byte_valid   = 1'b1;
        push_job.encode_error = 1'b0;
        push_job.last_idx     = '0;
        push_job.bytes        = '0;
        unique case (op_t'(s_axis_tuser))
            OP_CHAR:
            begin
                if (cp_bad)
                begin
                    push_job.byte_valid   = 1'b0;
                    push_job.encode_error = 1'b1;
                end
                else
                begin
                    push_job.bytes    = utf_bytes;
                    push_job.last_idx = utf_last;
                    if (cp == CP_CR)
                        col_next = '0;
                    else if (col_sum[COLUMN_BITS])
                        col_next = '1;
                    else
                        col_next = col_sum[COLUMN_BITS-1:0];
                end
            end
            OP_RAW:
            begin
                push_job.bytes[0] = cp[BYTE_W-1:0];
            end
            OP_NEWLINE:
            begin
                col_next          = '0;
                push_job.bytes[0] = CHAR_CR;
                push_job.bytes[1] = CHAR_LF;
                push_job.last_idx = 2'd1;
            end
            OP_FRESH:
            begin
                if (col_reg == '0)
                begin
                    push_job.byte_valid = 1'b0;
                end
                else
                begin
                    col_next          = '0;
                    push_job.bytes[0] = CHAR_CR;
                    push_job.bytes[1] = CHAR_LF;
                    push_job.last_idx = 2'd1;
                end
            end
            default:
            begin
                push_job.byte_valid = 1'b0;
            end
        endcase
        // Column reported is the low bits of the count after this item
        push_job.column = COLUMN_W'(col_next);
    end

    // Column state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            col_reg <= '0;
        else if (accept)
            col_reg <= col_next;
    end

endmodule

[sv/ute_queue.sv]
// Short FIFO of classified items between front and back.
module ute_queue #(
    parameter int DEPTH = ute_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ute_pkg::job_t     push_job,
    input  logic              pop,
    output ute_pkg::job_t     head_job,
    output ute_pkg::q_stat_t  q_stat
);
    import ute_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t            mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_next;
    logic            do_push;
    logic            do_pop;

    assign q_stat.full  = (count_reg == CW'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_job     = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

[sv/ute_back.sv]
// Back end: serializes queued items into single-byte results.
module ute_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ute_pkg::job_t                 head_job,
    input  logic                          head_valid,
    output logic                          pop,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] out_byte, [23:8] column
    output logic [ute_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // [0] byte_valid, [1] encode_error
    output logic [ute_pkg::M_TUSER_W-1:0] m_axis_tuser,
    output logic                          m_axis_tlast
);
    import ute_pkg::*;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [M_TDATA_W-1:0]          out_data_reg;
    logic [M_TUSER_W-1:0]          out_user_reg;
    logic                          out_last_reg;
    logic [IDX_W-1:0]              idx_reg;
    logic [IDX_W-1:0]              idx_next;
    logic                          adv;
    logic                          at_last;

    // Load the output register from the queue head whenever it is free or being drained
    assign adv     = head_valid && (!out_valid_reg || m_axis_tready);
    assign at_last = (idx_reg == head_job.last_idx);
    assign pop     = adv && at_last;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
            idx_next       = at_last ? '0 : idx_reg + 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= {head_job.column, head_job.bytes[idx_reg]};
            out_user_reg <= {head_job.encode_error, head_job.byte_valid};
            out_last_reg <= at_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

[sv/utf8_terminal_output_encoder_core.sv]
// UTF-8 terminal output encoder, top level.
// Input stream (s_axis_*): one item per operation. tuser carries op (write
// character, raw byte, newline, fresh line); tdata carries code_point in bits
// [20:0] and char_width in [28:21].
// Output stream (m_axis_*): one result per emitted byte. tdata holds out_byte
// in [7:0] and the column after the item in [23:8]; tuser holds byte_valid in
// bit 0 and encode_error in bit 1; tlast marks the final result of an item.
// An encode error or a fresh line at column zero gives one result with
// byte_valid low.
// An item taken is written into a queue entry, then loaded into the output
// register. Results leave at one per cycle while m_axis_tready is high; the
// one-byte output register sets this. The front classifies an item per cycle,
// while the default two-entry queue has room, so it takes items as output drains.
// Reset clears the column to zero and empties the queue and output register.
// A stall on m_axis_tready holds the current result; the queue then fills and
// s_axis_tready drops.
module utf8_terminal_output_encoder_core #(
    parameter int COLUMN_BITS = ute_pkg::COLUMN_BITS_DEF,
    parameter int QUEUE_DEPTH = ute_pkg::QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [20:0] code_point, [28:21] char_width, [31:29] zero
    input  logic [ute_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] op
    input  logic [ute_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] out_byte, [23:8] column
    output logic [ute_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // [0] byte_valid, [1] encode_error
    output logic [ute_pkg::M_TUSER_W-1:0] m_axis_tuser,
    output logic                          m_axis_tlast
);
    import ute_pkg::*;

    logic    push;
    logic    pop;
    job_t    push_job;
    job_t    head_job;
    q_stat_t q_stat;

    ute_front #(
        .COLUMN_BITS (COLUMN_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_stat        (q_stat),
        .push          (push),
        .push_job      (push_job)
    );

    ute_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_stat   (q_stat)
    );

    ute_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_job      (head_job),
        .head_valid    (!q_stat.empty),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // An error result is a lone result carrying no byte
    a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tlast && !m_axis_tuser[0]))
        else $error("encode error result not a lone empty result");

    // Results before the last one of an item always carry a byte
    a_mid_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> m_axis_tuser[0])
        else $error("non-final result without a byte");

    // The front never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("push into full queue");

    // A popped queue entry was at the head and the output register took it
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> m_axis_tvalid && m_axis_tlast)
        else $error("pop without a final result loaded");

endmodule
